### src/svpd_pkg.sv
// ============================================================================
// svpd_pkg
// Shared widths, constants and types for the space-vector PWM duty pipeline.
// ============================================================================
package svpd_pkg;

  // Field widths
  localparam int VOLT_W  = 16;            // signed voltage inputs
  localparam int FRAC    = 15;            // duty fraction bits (1.0 = 2^FRAC)
  localparam int DUTY_W  = FRAC + 1;      // duty output width
  localparam int SECT_W  = 3;             // sector number width

  // Divider geometry: |num| = 3*|v|*2^FRAC, den = 2*vdc
  localparam int MAG3_W  = VOLT_W + 1;          // 3*|v|
  localparam int NUM_W   = MAG3_W + FRAC;       // dividend width
  localparam int DEN_W   = VOLT_W;              // divisor width
  localparam int QB      = FRAC + 3;            // quotient bits (up to 4.0, plus margin)
  localparam int A_W     = QB + 1;              // signed normalized value width
  localparam int DIV_STEP = 2;                  // quotient bits per stage
  localparam int DIV_STG  = QB / DIV_STEP;      // iteration stages
  localparam int DIV_LAT  = DIV_STG + 2;        // request to quotient, in cycles

  // Saturation limit of normalized values: 4.0
  localparam logic [QB-1:0] NORM_LIM = QB'(4) << FRAC;

  // Top-level latency from accepted beat to result strobe
  localparam int PIPE_LAT = DIV_LAT + 6;

  // Sector codes
  localparam logic [SECT_W-1:0] SECT_NONE = 3'd0;
  localparam logic [SECT_W-1:0] SECT_1    = 3'd1;
  localparam logic [SECT_W-1:0] SECT_2    = 3'd2;
  localparam logic [SECT_W-1:0] SECT_3    = 3'd3;
  localparam logic [SECT_W-1:0] SECT_4    = 3'd4;
  localparam logic [SECT_W-1:0] SECT_5    = 3'd5;
  localparam logic [SECT_W-1:0] SECT_6    = 3'd6;

  // Divider request bundle
  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } svpd_div_req_t;

endpackage

### src/svpd_div.sv
// ============================================================================
// svpd_div
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with
// truncation toward zero and saturation of the signed result to +/-4.0.
// ============================================================================
module svpd_div import svpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svpd_div_req_t         req,
  output logic                  quo_vld,
  output logic signed [A_W-1:0] quo
);

  // Stage registers, index 0 holds the loaded request
  logic             vld_r [DIV_STG+1];
  logic             neg_r [DIV_STG+1];
  logic             ovf_r [DIV_STG+1];
  logic [QB-1:0]    num_r [DIV_STG+1];
  logic [DEN_W-1:0] den_r [DIV_STG+1];
  logic [DEN_W-1:0] rem_r [DIV_STG+1];
  logic [QB-1:0]    q_r   [DIV_STG+1];

  logic [DEN_W-1:0] rem_nxt [DIV_STG];
  logic [QB-1:0]    q_nxt   [DIV_STG];

  logic                  quo_vld_r;
  logic signed [A_W-1:0] quo_r;
  logic signed [A_W-1:0] quo_nxt;

  logic ovf_in;

  // Quotient would not fit in QB bits: saturate later
  assign ovf_in = DEN_W'(req.num[NUM_W-1:QB]) >= req.den;

  // Two restoring steps per stage
  always_comb begin
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    q;
    logic [DEN_W:0]   rs;
    for (int s = 0; s < DIV_STG; s++) begin
      rem = rem_r[s];
      q   = q_r[s];
      for (int j = 0; j < DIV_STEP; j++) begin
        rs = {rem, num_r[s][QB-1-(s*DIV_STEP+j)]};
        if (rs >= {1'b0, den_r[s]}) begin
          rem = DEN_W'(rs - {1'b0, den_r[s]});
          q   = {q[QB-2:0], 1'b1};
        end else begin
          rem = rs[DEN_W-1:0];
          q   = {q[QB-2:0], 1'b0};
        end
      end
      rem_nxt[s] = rem;
      q_nxt[s]   = q;
    end
  end

  // Sign and saturation of the final quotient
  always_comb begin
    logic [QB-1:0]         mag;
    logic signed [A_W-1:0] mag_s;
    if (ovf_r[DIV_STG] || (q_r[DIV_STG] > NORM_LIM)) begin
      mag = NORM_LIM;
    end else begin
      mag = q_r[DIV_STG];
    end
    mag_s   = $signed(A_W'(mag));
    quo_nxt = neg_r[DIV_STG] ? -mag_s : mag_s;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STG; s++) begin
        vld_r[s] <= 1'b0;
      end
      quo_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= req.vld;
      for (int s = 0; s < DIV_STG; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
      quo_vld_r <= vld_r[DIV_STG];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    neg_r[0] <= req.neg;
    ovf_r[0] <= ovf_in;
    num_r[0] <= req.num[QB-1:0];
    den_r[0] <= req.den;
    rem_r[0] <= DEN_W'(req.num[NUM_W-1:QB]);
    q_r[0]   <= '0;
    for (int s = 0; s < DIV_STG; s++) begin
      neg_r[s+1] <= neg_r[s];
      ovf_r[s+1] <= ovf_r[s];
      num_r[s+1] <= num_r[s];
      den_r[s+1] <= den_r[s];
      rem_r[s+1] <= rem_nxt[s];
      q_r[s+1]   <= q_nxt[s];
    end
    quo_r <= quo_nxt;
  end

  assign quo_vld = quo_vld_r;
  assign quo     = quo_r;

endmodule

### src/space_vector_pwm_duty.sv
// Throughput: one beat per cycle; busy is always low.
// Each beat passes the input register, the pipelined divider (two quotient
// bits per stage), and the multiply, sector, timing, centering and clamp
// stages, in that order.
// Reset (rst_n low, synchronous) clears only the valid bits of the pipeline.
// ============================================================================
// space_vector_pwm_duty
// Space-vector PWM duty generator: normalize alpha/beta by bus voltage,
// find the sector, compute t1/t2 and center the three phase duties.
// ============================================================================
module space_vector_pwm_duty import svpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [VOLT_W-1:0] in_v_alpha,
  input  logic signed [VOLT_W-1:0] in_v_beta,
  input  logic signed [VOLT_W-1:0] in_bus_voltage,
  output logic                     out_valid,
  output logic [DUTY_W-1:0]        out_duty_a,
  output logic [DUTY_W-1:0]        out_duty_b,
  output logic [DUTY_W-1:0]        out_duty_c,
  output logic [SECT_W-1:0]        out_sector_number
);

  localparam int SQ_W  = 2 * A_W;        // squares
  localparam int SQ3_W = SQ_W + 2;       // 3*a^2
  localparam int P_W   = A_W + 18;       // b * K
  localparam int T_W   = FRAC + 9;       // timing and raw duty width

  localparam logic signed [17:0]    K_INV_SQRT3 = 18'sd37837;  // Q16 1/sqrt3
  localparam logic signed [P_W:0]   P_RND       = (P_W+1)'(32768);
  localparam logic signed [T_W-1:0] T_ONE       = T_W'(1) << FRAC;
  localparam logic [DUTY_W-1:0]     D_ONE       = DUTY_W'(1) << FRAC;
  localparam logic [DUTY_W-1:0]     D_HALF      = DUTY_W'(1) << (FRAC - 1);

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Input register
  logic                     s0_vld_r;
  logic signed [VOLT_W-1:0] s0_va_r;
  logic signed [VOLT_W-1:0] s0_vb_r;
  logic signed [VOLT_W-1:0] s0_vdc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_va_r  <= in_v_alpha;
    s0_vb_r  <= in_v_beta;
    s0_vdc_r <= in_bus_voltage;
  end

  // --------------------------------------------------------------------------
  // Divider requests: |3*v*2^F| over 2*vdc, sign kept aside
  function automatic logic [NUM_W-1:0] scaled_mag(input logic signed [VOLT_W-1:0] v);
    logic [VOLT_W-1:0] mag;
    logic [MAG3_W-1:0] mag3;
    mag  = v[VOLT_W-1] ? VOLT_W'(-v) : VOLT_W'(v);
    mag3 = MAG3_W'(mag) + {mag, 1'b0};
    return {mag3, {FRAC{1'b0}}};
  endfunction

  svpd_div_req_t     req_a;
  svpd_div_req_t     req_b;
  logic [DEN_W-1:0]  den;
  logic              bad_in;

  assign den    = {s0_vdc_r[VOLT_W-2:0], 1'b0};
  assign bad_in = s0_vdc_r[VOLT_W-1] || (s0_vdc_r == '0);

  assign req_a = '{vld: s0_vld_r, neg: s0_va_r[VOLT_W-1], num: scaled_mag(s0_va_r), den: den};
  assign req_b = '{vld: s0_vld_r, neg: s0_vb_r[VOLT_W-1], num: scaled_mag(s0_vb_r), den: den};

  logic                  qa_vld;
  logic                  qb_vld;
  logic signed [A_W-1:0] norm_a;
  logic signed [A_W-1:0] norm_b;

  svpd_div u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_a),
    .quo_vld (qa_vld),
    .quo     (norm_a)
  );

  svpd_div u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_b),
    .quo_vld (qb_vld),
    .quo     (norm_b)
  );

  // Invalid-bus flag rides alongside the divider
  logic bad_d_r [DIV_LAT];

  always_ff @(posedge clk) begin
    bad_d_r[0] <= bad_in;
    for (int i = 1; i < DIV_LAT; i++) begin
      bad_d_r[i] <= bad_d_r[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // P1: squares and b*K
  logic                  p1_vld_r;
  logic                  p1_bad_r;
  logic signed [A_W-1:0] p1_a_r;
  logic signed [A_W-1:0] p1_b_r;
  logic signed [SQ_W-1:0] p1_aa_r;
  logic signed [SQ_W-1:0] p1_bb_r;
  logic signed [P_W-1:0]  p1_bk_r;

  always_ff @(posedge clk) begin
    p1_bad_r <= bad_d_r[DIV_LAT-1];
    p1_a_r   <= norm_a;
    p1_b_r   <= norm_b;
    p1_aa_r  <= norm_a * norm_a;
    p1_bb_r  <= norm_b * norm_b;
    p1_bk_r  <= norm_b * K_INV_SQRT3;
  end

  // --------------------------------------------------------------------------
  // P2: sector decision and rounded products
  logic signed [SQ3_W-1:0] aa_x;
  logic signed [SQ3_W-1:0] a2;
  logic signed [SQ3_W-1:0] b2;
  logic signed [P_W:0]     bk_x;
  logic signed [P_W:0]     m1_x;
  logic signed [P_W:0]     m2_x;
  logic [SECT_W-1:0]       sect_nxt;

  assign aa_x = SQ3_W'(p1_aa_r);
  assign a2   = aa_x + (aa_x <<< 1);
  assign b2   = SQ3_W'(p1_bb_r);
  assign bk_x = (P_W+1)'(p1_bk_r);
  assign m1_x = (bk_x + P_RND) >>> 16;
  assign m2_x = ((bk_x <<< 1) + P_RND) >>> 16;

  always_comb begin
    if (!p1_b_r[A_W-1]) begin
      if (!p1_a_r[A_W-1]) begin
        sect_nxt = (b2 > a2) ? SECT_2 : SECT_1;
      end else begin
        sect_nxt = (b2 < a2) ? SECT_3 : SECT_2;
      end
    end else begin
      if (!p1_a_r[A_W-1]) begin
        sect_nxt = (b2 > a2) ? SECT_5 : SECT_6;
      end else begin
        sect_nxt = (b2 < a2) ? SECT_4 : SECT_5;
      end
    end
  end

  logic                  p2_vld_r;
  logic                  p2_bad_r;
  logic [SECT_W-1:0]     p2_sect_r;
  logic signed [T_W-1:0] p2_a_r;
  logic signed [T_W-1:0] p2_m1_r;
  logic signed [T_W-1:0] p2_m2_r;

  always_ff @(posedge clk) begin
    p2_bad_r  <= p1_bad_r;
    p2_sect_r <= sect_nxt;
    p2_a_r    <= T_W'(p1_a_r);
    p2_m1_r   <= m1_x[T_W-1:0];
    p2_m2_r   <= m2_x[T_W-1:0];
  end

  // --------------------------------------------------------------------------
  // P3: active-vector times per sector
  logic signed [T_W-1:0] t1_nxt;
  logic signed [T_W-1:0] t2_nxt;

  always_comb begin
    case (p2_sect_r)
      SECT_1: begin
        t1_nxt = p2_a_r - p2_m1_r;
        t2_nxt = p2_m2_r;
      end
      SECT_2: begin
        t1_nxt = p2_a_r + p2_m1_r;
        t2_nxt = p2_m1_r - p2_a_r;
      end
      SECT_3: begin
        t1_nxt = p2_m2_r;
        t2_nxt = -p2_a_r - p2_m1_r;
      end
      SECT_4: begin
        t1_nxt = p2_m1_r - p2_a_r;
        t2_nxt = -p2_m2_r;
      end
      SECT_5: begin
        t1_nxt = -p2_a_r - p2_m1_r;
        t2_nxt = p2_a_r - p2_m1_r;
      end
      default: begin
        t1_nxt = -p2_m2_r;
        t2_nxt = p2_a_r + p2_m1_r;
      end
    endcase
  end

  logic                  p3_vld_r;
  logic                  p3_bad_r;
  logic [SECT_W-1:0]     p3_sect_r;
  logic signed [T_W-1:0] p3_t1_r;
  logic signed [T_W-1:0] p3_t2_r;

  always_ff @(posedge clk) begin
    p3_bad_r  <= p2_bad_r;
    p3_sect_r <= p2_sect_r;
    p3_t1_r   <= t1_nxt;
    p3_t2_r   <= t2_nxt;
  end

  // --------------------------------------------------------------------------
  // P4: centered leading phase, others by subtraction
  logic signed [T_W-1:0] lead;
  logic signed [T_W-1:0] da_nxt;
  logic signed [T_W-1:0] db_nxt;
  logic signed [T_W-1:0] dc_nxt;

  assign lead = (T_ONE + p3_t1_r + p3_t2_r) >>> 1;

  always_comb begin
    case (p3_sect_r)
      SECT_1: begin
        da_nxt = lead;
        db_nxt = da_nxt - p3_t1_r;
        dc_nxt = db_nxt - p3_t2_r;
      end
      SECT_2: begin
        db_nxt = lead;
        da_nxt = db_nxt - p3_t2_r;
        dc_nxt = da_nxt - p3_t1_r;
      end
      SECT_3: begin
        db_nxt = lead;
        dc_nxt = db_nxt - p3_t1_r;
        da_nxt = dc_nxt - p3_t2_r;
      end
      SECT_4: begin
        dc_nxt = lead;
        db_nxt = dc_nxt - p3_t2_r;
        da_nxt = db_nxt - p3_t1_r;
      end
      SECT_5: begin
        dc_nxt = lead;
        da_nxt = dc_nxt - p3_t1_r;
        db_nxt = da_nxt - p3_t2_r;
      end
      default: begin
        da_nxt = lead;
        dc_nxt = da_nxt - p3_t2_r;
        db_nxt = dc_nxt - p3_t1_r;
      end
    endcase
  end

  logic                  p4_vld_r;
  logic                  p4_bad_r;
  logic [SECT_W-1:0]     p4_sect_r;
  logic signed [T_W-1:0] p4_da_r;
  logic signed [T_W-1:0] p4_db_r;
  logic signed [T_W-1:0] p4_dc_r;

  always_ff @(posedge clk) begin
    p4_bad_r  <= p3_bad_r;
    p4_sect_r <= p3_sect_r;
    p4_da_r   <= da_nxt;
    p4_db_r   <= db_nxt;
    p4_dc_r   <= dc_nxt;
  end

  // --------------------------------------------------------------------------
  // P5: clamp to 0..1, neutral output on invalid bus
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [T_W-1:0] d);
    if (d[T_W-1]) begin
      return '0;
    end else if (d > T_ONE) begin
      return D_ONE;
    end else begin
      return d[DUTY_W-1:0];
    end
  endfunction

  logic                out_valid_r;
  logic [DUTY_W-1:0]   duty_a_r;
  logic [DUTY_W-1:0]   duty_b_r;
  logic [DUTY_W-1:0]   duty_c_r;
  logic [SECT_W-1:0]   sector_r;

  always_ff @(posedge clk) begin
    if (p4_bad_r) begin
      duty_a_r <= D_HALF;
      duty_b_r <= D_HALF;
      duty_c_r <= D_HALF;
      sector_r <= SECT_NONE;
    end else begin
      duty_a_r <= clamp_duty(p4_da_r);
      duty_b_r <= clamp_duty(p4_db_r);
      duty_c_r <= clamp_duty(p4_dc_r);
      sector_r <= p4_sect_r;
    end
  end

  // Valid bits after the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_vld_r    <= qa_vld && qb_vld;
      p2_vld_r    <= p1_vld_r;
      p3_vld_r    <= p2_vld_r;
      p4_vld_r    <= p3_vld_r;
      out_valid_r <= p4_vld_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duty_a        = duty_a_r;
  assign out_duty_b        = duty_b_r;
  assign out_duty_c        = duty_c_r;
  assign out_sector_number = sector_r;

  // --------------------------------------------------------------------------
  // Checks

  // Every accepted beat later yields its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("result strobe missing after accepted beat");

  // Both divider lanes stay in lock step
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    qa_vld == qb_vld)
    else $error("divider lanes out of step");

  // Neutral output carries half duties on all phases
  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_sector_number == SECT_NONE)) |->
      ((out_duty_a == D_HALF) && (out_duty_b == D_HALF) && (out_duty_c == D_HALF)))
    else $error("invalid bus result without half duties");

  // Duties never exceed full on
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_duty_a <= D_ONE) && (out_duty_b <= D_ONE) && (out_duty_c <= D_ONE)))
    else $error("duty above full scale");

endmodule

### sim/svpd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// svpd_checker
// Watches the request and result channels of the space-vector PWM duty
// block, computes the expected duties and sector for every accepted beat,
// and compares each result strobe against the oldest pending expectation.
// ============================================================================
module svpd_checker import svpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [VOLT_W-1:0] in_v_alpha,
  input  logic signed [VOLT_W-1:0] in_v_beta,
  input  logic signed [VOLT_W-1:0] in_bus_voltage,
  input  logic                     out_valid,
  input  logic [DUTY_W-1:0]        out_duty_a,
  input  logic [DUTY_W-1:0]        out_duty_b,
  input  logic [DUTY_W-1:0]        out_duty_c,
  input  logic [SECT_W-1:0]        out_sector_number,
  output int                       mismatch_cnt,
  output int                       pending_cnt,
  output int                       beats_in,
  output int                       results_seen,
  output logic [6:0]               sector_seen
);

  // 1/sqrt3 and 2/sqrt3 in Q16
  localparam longint K_INV_SQRT3 = 37837;
  localparam longint K_TWO_SQRT3 = 75674;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [SECT_W-1:0] sector;
  } duty_set_t;

  duty_set_t duty_q[$];
  int        n_fail = 0;
  int        n_in   = 0;
  int        n_out  = 0;
  logic [6:0] seen  = '0;

  // Q16 product, rounded half up (arithmetic shift floors)
  function automatic longint q16_round(longint x, longint k);
    return (x * k + 32768) >>> 16;
  endfunction

  function automatic longint duty_clamp(longint d);
    longint full;
    full = longint'(1) << FRAC;
    if (d > full) return full;
    if (d < 0) return 0;
    return d;
  endfunction

  // Expected duties and sector for one request
  function automatic duty_set_t svm_duty_predict(longint va, longint vb, longint vdc);
    longint full, lim, na, nb, a_sq, b_sq, b_inv, b_two, t1, t2, da, db, dc;
    logic [SECT_W-1:0] sect;
    duty_set_t r;
    full = longint'(1) << FRAC;
    lim  = 4 * full;
    // neutral output on a dead or reversed bus
    if (vdc <= 0) begin
      r.duty_a = DUTY_W'(full / 2);
      r.duty_b = DUTY_W'(full / 2);
      r.duty_c = DUTY_W'(full / 2);
      r.sector = SECT_NONE;
      return r;
    end
    // normalize to 1.5*v/vdc, truncated toward zero, then saturate at 4.0
    na = (3 * va * full) / (2 * vdc);
    nb = (3 * vb * full) / (2 * vdc);
    if (na > lim) na = lim;
    if (na < -lim) na = -lim;
    if (nb > lim) nb = lim;
    if (nb < -lim) nb = -lim;
    // sector from squared comparisons
    a_sq = 3 * na * na;
    b_sq = nb * nb;
    if (nb >= 0) begin
      if (na >= 0) sect = (b_sq > a_sq) ? SECT_2 : SECT_1;
      else         sect = (b_sq < a_sq) ? SECT_3 : SECT_2;
    end else begin
      if (na >= 0) sect = (b_sq > a_sq) ? SECT_5 : SECT_6;
      else         sect = (b_sq < a_sq) ? SECT_4 : SECT_5;
    end
    b_inv = q16_round(nb, K_INV_SQRT3);
    b_two = q16_round(nb, K_TWO_SQRT3);
    // active-vector times and centered duties per sector
    case (sect)
      SECT_1: begin
        t1 = na - b_inv;  t2 = b_two;
        da = (full + t1 + t2) >>> 1;  db = da - t1;  dc = db - t2;
      end
      SECT_2: begin
        t1 = na + b_inv;  t2 = -na + b_inv;
        db = (full + t1 + t2) >>> 1;  da = db - t2;  dc = da - t1;
      end
      SECT_3: begin
        t1 = b_two;  t2 = -na - b_inv;
        db = (full + t1 + t2) >>> 1;  dc = db - t1;  da = dc - t2;
      end
      SECT_4: begin
        t1 = -na + b_inv;  t2 = -b_two;
        dc = (full + t1 + t2) >>> 1;  db = dc - t2;  da = db - t1;
      end
      SECT_5: begin
        t1 = -na - b_inv;  t2 = na - b_inv;
        dc = (full + t1 + t2) >>> 1;  da = dc - t1;  db = da - t2;
      end
      default: begin
        t1 = -b_two;  t2 = na + b_inv;
        da = (full + t1 + t2) >>> 1;  dc = da - t2;  db = dc - t1;
      end
    endcase
    r.duty_a = DUTY_W'(duty_clamp(da));
    r.duty_b = DUTY_W'(duty_clamp(db));
    r.duty_c = DUTY_W'(duty_clamp(dc));
    r.sector = sect;
    return r;
  endfunction

  // Compare results, then queue the expectation of an accepted beat
  always @(posedge clk) begin
    duty_set_t want;
    if (rst_n) begin
      if (out_valid) begin
        n_out++;
        if (out_sector_number < 7) seen[out_sector_number] = 1'b1;
        if (duty_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] unexpected result: a=%0d b=%0d c=%0d sector=%0d",
                     $realtime, out_duty_a, out_duty_b, out_duty_c, out_sector_number);
        end else begin
          want = duty_q.pop_front();
          if (out_duty_a !== want.duty_a || out_duty_b !== want.duty_b ||
              out_duty_c !== want.duty_c || out_sector_number !== want.sector) begin
            n_fail++;
            if (n_fail <= 10)
              $display("[%0t] mismatch: exp a=%0d b=%0d c=%0d s=%0d, got a=%0d b=%0d c=%0d s=%0d",
                       $realtime, want.duty_a, want.duty_b, want.duty_c, want.sector,
                       out_duty_a, out_duty_b, out_duty_c, out_sector_number);
          end
        end
      end
      if (start && !busy) begin
        n_in++;
        duty_q.push_back(svm_duty_predict(in_v_alpha, in_v_beta, in_bus_voltage));
      end
    end
    // published as registered values so readers never race the queue
    mismatch_cnt <= n_fail;
    pending_cnt  <= duty_q.size();
    beats_in     <= n_in;
    results_seen <= n_out;
    sector_seen  <= seen;
  end

endmodule

### sim/tb_space_vector_pwm_duty.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_space_vector_pwm_duty
// Drives directed and random alpha/beta/bus requests with random gaps into
// the space-vector PWM duty block; the checker scores every result strobe.
// ============================================================================
module tb_space_vector_pwm_duty;
  import svpd_pkg::*;

  localparam int N_RANDOM       = 1100;
  localparam int WATCHDOG_LIMIT = 500;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [VOLT_W-1:0] in_v_alpha;
  logic signed [VOLT_W-1:0] in_v_beta;
  logic signed [VOLT_W-1:0] in_bus_voltage;
  logic                     out_valid;
  logic [DUTY_W-1:0]        out_duty_a;
  logic [DUTY_W-1:0]        out_duty_b;
  logic [DUTY_W-1:0]        out_duty_c;
  logic [SECT_W-1:0]        out_sector_number;

  int         mismatch_cnt;
  int         pending_cnt;
  int         beats_in;
  int         results_seen;
  logic [6:0] sector_seen;
  int         idle_cycles = 0;
  bit         gaps_on;

  space_vector_pwm_duty DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_v_alpha        (in_v_alpha),
    .in_v_beta         (in_v_beta),
    .in_bus_voltage    (in_bus_voltage),
    .out_valid         (out_valid),
    .out_duty_a        (out_duty_a),
    .out_duty_b        (out_duty_b),
    .out_duty_c        (out_duty_c),
    .out_sector_number (out_sector_number)
  );

  svpd_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_v_alpha        (in_v_alpha),
    .in_v_beta         (in_v_beta),
    .in_bus_voltage    (in_bus_voltage),
    .out_valid         (out_valid),
    .out_duty_a        (out_duty_a),
    .out_duty_b        (out_duty_b),
    .out_duty_c        (out_duty_c),
    .out_sector_number (out_sector_number),
    .mismatch_cnt      (mismatch_cnt),
    .pending_cnt       (pending_cnt),
    .beats_in          (beats_in),
    .results_seen      (results_seen),
    .sector_seen       (sector_seen)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: cycles with neither a beat nor a result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL space_vector_pwm_duty");
      $finish;
    end
  end

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Uniform value in [-m, m]
  function automatic int span(int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  // Present one request and hold it until accepted
  task automatic drive_request(input int va, input int vb, input int vdc);
    in_v_alpha     <= VOLT_W'(va);
    in_v_beta      <= VOLT_W'(vb);
    in_bus_voltage <= VOLT_W'(vdc);
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random gap after a beat, with junk on the data ports
  task automatic sender_gap();
    int n;
    n = gaps_on ? int'($urandom_range(6)) : 0;
    if (n > 0) begin
      start          <= 1'b0;
      in_v_alpha     <= VOLT_W'($urandom);
      in_v_beta      <= VOLT_W'($urandom);
      in_bus_voltage <= VOLT_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic request(input int va, input int vb, input int vdc);
    drive_request(va, vb, vdc);
    sender_gap();
  endtask

  initial begin
    int kind, vdc, va, vb, m;
    start          = 1'b0;
    in_v_alpha     = '0;
    in_v_beta      = '0;
    in_bus_voltage = '0;
    rst_n          = 1'b0;
    gaps_on        = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dead or reversed bus gives neutral duties
    request(1000, -2000, 0);
    request(-32768, 32767, -1);
    request(32767, 32767, -32768);
    // zero request
    request(0, 0, 1000);
    // axis borders between sector halves
    request(1000, 0, 2000);
    request(0, 1000, 2000);
    request(-1000, 0, 2000);
    request(0, -1000, 2000);
    // sector centers
    request(866, 500, 2000);
    request(-866, 500, 2000);
    request(-866, -500, 2000);
    request(866, -500, 2000);
    // near the 60 degree borders
    request(500, 866, 1500);
    request(500, 867, 1500);
    request(-500, 866, 1500);
    request(-500, -866, 1500);
    request(500, -867, 1500);
    // oversized requests saturate, extreme field values
    request(32767, 32767, 1);
    request(-32768, -32768, 1);
    request(32767, -32768, 32767);
    request(-32768, 32767, 32767);
    request(1, -1, 32767);
    request(32767, 0, 32767);

    // Random: mostly realistic requests, some edge and junk traffic
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(2) != 0);
      kind = $urandom_range(99);
      if (kind < 8) begin
        vdc = -int'($urandom_range(32768));
        va  = clip16(span(32768));
        vb  = clip16(span(32768));
      end else if (kind < 25) begin
        vdc = int'($signed(16'($urandom)));
        va  = int'($signed(16'($urandom)));
        vb  = int'($signed(16'($urandom)));
      end else if (kind < 40) begin
        // along a 60 degree border, within a couple of LSBs
        vdc = $urandom_range(1, 32767);
        va  = span(vdc / 2);
        vb  = ((va * 56756) >>> 15) + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) vb = -vb;
        vb  = clip16(vb);
      end else if (kind < 50) begin
        vdc = $urandom_range(1, 64);
        va  = span(300);
        vb  = span(300);
      end else begin
        vdc = $urandom_range(100, 32767);
        m   = ($urandom_range(3) == 0) ? vdc : (vdc * 2) / 3;
        va  = clip16(span(m));
        vb  = clip16(span(m));
      end
      request(va, vb, vdc);
    end

    // Drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);

    $display("Run covered %0d request beats and %0d result strobes, %0d mismatches.",
             beats_in, results_seen, mismatch_cnt);
    $display("Sectors observed (bit 0 is neutral): %b", sector_seen);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS space_vector_pwm_duty");
    end else begin
      $display("FAIL space_vector_pwm_duty");
    end
    $finish;
  end

endmodule
